// ===== rtl/lcl_pkg.sv =====
// Shared types and constants for the LRU cache lookup block.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package lcl_pkg;

  localparam int LclIdW   = 64;  // object identifier width
  localparam int LclMissW = 32;  // miss counter width
  localparam int LclCapW  = 5;   // capacity register width
  localparam int LclCntW  = 9;   // holds any way count or index up to 256

  typedef enum logic {
    LCL_IDLE,
    LCL_UPDATE
  } lcl_state_e;

  // Broadcast from the controller to every cell of the row.
  typedef struct packed {
    logic               commit;  // update the row this cycle
    logic [LclCntW-1:0] limit;   // highest position that takes its neighbour's id
    logic [LclCntW-1:0] count;   // number of resident entries
  } lcl_cmd_t;

endpackage
`default_nettype wire

// ===== rtl/lcl_req_if.sv =====
// Request channel: one object identifier per word.
// Depends on lcl_pkg.
`default_nettype none
interface lcl_req_if;
  import lcl_pkg::*;

  logic              valid;
  logic              ready;
  logic [LclIdW-1:0] object_id;

  modport source (output valid, output object_id, input ready);
  modport sink   (input valid, input object_id, output ready);
endinterface
`default_nettype wire

// ===== rtl/lcl_rsp_if.sv =====
// Response channel: hit, eviction report and running miss count per word.
// Depends on lcl_pkg.
`default_nettype none
interface lcl_rsp_if;
  import lcl_pkg::*;

  logic                valid;
  logic                ready;
  logic                hit;
  logic                evicted;
  logic [LclIdW-1:0]   evicted_id;
  logic [LclMissW-1:0] miss_count;

  modport source (output valid, output hit, output evicted, output evicted_id,
                  output miss_count, input ready);
  modport sink   (input valid, input hit, input evicted, input evicted_id,
                  input miss_count, output ready);
endinterface
`default_nettype wire

// ===== rtl/lcl_cell.sv =====
// One position of the recency row: holds an identifier, matches it against
// the probe and takes its neighbour's identifier on a shift. Uses lcl_pkg.
`default_nettype none
module lcl_cell #(
  parameter int Idx = 0
) (
  input  wire                     clk_i,
  input  wire [lcl_pkg::LclIdW-1:0] probe_id_i,
  input  wire [lcl_pkg::LclIdW-1:0] prev_id_i,
  input  lcl_pkg::lcl_cmd_t       cmd_i,
  output logic [lcl_pkg::LclIdW-1:0] id_o,
  output logic                    match_o
);
  import lcl_pkg::*;

  localparam logic [LclCntW-1:0] Pos = LclCntW'(Idx);

  logic [LclIdW-1:0] id_q;
  logic [LclIdW-1:0] id_d;
  logic              load;

  // take the neighbour's id when at or below the shift limit
  assign load = cmd_i.commit && (Pos <= cmd_i.limit);
  assign id_d = load ? prev_id_i : id_q;

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign id_o    = id_q;
  assign match_o = (Pos < cmd_i.count) && (id_q == probe_id_i);
endmodule
`default_nettype wire

// ===== rtl/lru_cache_lookup.sv =====
// Fully associative cache directory with least-recently-used replacement.
// Depends on lcl_pkg, lcl_req_if, lcl_rsp_if and lcl_cell.
`default_nettype none
// The directory is a row of WAYS cells kept in recency order: position 0
// holds the most recent identifier, position count-1 the least recent. In
// the cycle a word is accepted, every resident cell compares its identifier
// with the request at once and the hit position is encoded and registered.
// In the update state, the row of cells shifts by one from the
// front up to a limit (the hit position on a hit, the last resident position
// on a miss with the directory full, one past it otherwise), the request
// enters position 0, and the result is loaded into the output register.
// Whatever falls off the last resident position is reported as evicted.
// The output register lets the next word be accepted while a result still
// waits; the update only stalls when that register is full and not
// being drained. Capacity is clamped to 1..WAYS; lowering it below the
// resident count evicts on each miss without shrinking the row. The miss
// counter saturates at its maximum. Write capacity only while idle.
module lru_cache_lookup #(
  parameter int WAYS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [lcl_pkg::LclCapW-1:0]   cfg_wdata_i,
  lcl_req_if.sink                      req,
  lcl_rsp_if.source                    rsp
);
  import lcl_pkg::*;

  localparam int CntW = $clog2(WAYS + 1);
  localparam int PosW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [LclCntW-1:0] WaysC = LclCntW'(WAYS);

  lcl_state_e state_q, state_d;

  logic [LclCapW-1:0]  cap_q;
  logic [CntW-1:0]     count_q, count_d;
  logic [LclMissW-1:0] miss_q, miss_d;
  logic [LclIdW-1:0]   id_q;
  logic                hit_q;
  logic [PosW-1:0]     hit_pos_q;

  logic                out_valid_q;
  logic                out_hit_q, out_ev_q;
  logic [LclIdW-1:0]   out_ev_id_q;
  logic [LclMissW-1:0] out_miss_q;

  logic [LclIdW-1:0]   cell_id [WAYS];
  logic [WAYS-1:0]     match;
  logic [PosW-1:0]     match_pos;
  lcl_cmd_t            cmd;

  logic                accept, commit, out_free;
  logic [LclCntW-1:0]  cnt9, eff_cap, last_pos;
  logic                full;
  logic [LclIdW-1:0]   lru_id;

  // ---- row of cells ----
  for (genvar k = 0; k < WAYS; k++) begin : g_cell
    logic [LclIdW-1:0] prev_id;
    if (k == 0) begin : g_head
      assign prev_id = id_q;
    end else begin : g_body
      assign prev_id = cell_id[k-1];
    end
    lcl_cell #(.Idx(k)) u_cell (
      .clk_i      (clk_i),
      .probe_id_i (req.object_id),
      .prev_id_i  (prev_id),
      .cmd_i      (cmd),
      .id_o       (cell_id[k]),
      .match_o    (match[k])
    );
  end

  // encode the hit position; at most one cell matches
  always_comb begin
    match_pos = '0;
    for (int k = 0; k < WAYS; k++) begin
      if (match[k]) begin
        match_pos = match_pos | PosW'(k);
      end
    end
  end

  // ---- occupancy and victim ----
  assign cnt9     = LclCntW'(count_q);
  assign last_pos = cnt9 - LclCntW'(1);
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = LclCntW'(1);
    end else if (LclCntW'(cap_q) > WaysC) begin
      eff_cap = WaysC;
    end else begin
      eff_cap = LclCntW'(cap_q);
    end
  end
  assign full = (cnt9 >= eff_cap);

  // identifier about to fall off the least recent position
  always_comb begin
    lru_id = '0;
    for (int k = 0; k < WAYS; k++) begin
      if (LclCntW'(k) == last_pos) begin
        lru_id = lru_id | cell_id[k];
      end
    end
  end

  // ---- control ----
  assign out_free = !out_valid_q || rsp.ready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      LCL_IDLE:   if (req.valid) state_d = LCL_UPDATE;
      LCL_UPDATE: if (out_free)  state_d = LCL_IDLE;
      default:    state_d = LCL_IDLE;
    endcase
  end

  always_comb begin
    req.ready = 1'b0;
    commit    = 1'b0;
    case (state_q)
      LCL_IDLE:   req.ready = 1'b1;
      LCL_UPDATE: commit    = out_free;
      default:    ;
    endcase
  end

  assign accept = req.valid && req.ready;

  always_comb begin
    cmd.commit = commit;
    cmd.count  = cnt9;
    if (hit_q) begin
      cmd.limit = LclCntW'(hit_pos_q);
    end else if (full) begin
      cmd.limit = last_pos;
    end else begin
      cmd.limit = cnt9;
    end
  end

  // grow on a miss with room left; saturate the miss counter
  assign count_d = (!hit_q && !full) ? count_q + CntW'(1) : count_q;
  assign miss_d  = (!hit_q && (miss_q != '1)) ? miss_q + LclMissW'(1) : miss_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= LCL_IDLE;
      cap_q       <= LclCapW'(16);
      count_q     <= '0;
      miss_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
      if (commit) begin
        count_q     <= count_d;
        miss_q      <= miss_d;
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the request and its lookup result for the update cycle
  always_ff @(posedge clk_i) begin
    if (accept) begin
      id_q      <= req.object_id;
      hit_q     <= |match;
      hit_pos_q <= match_pos;
    end
    if (commit) begin
      out_hit_q   <= hit_q;
      out_ev_q    <= !hit_q && full;
      out_ev_id_q <= (!hit_q && full) ? lru_id : '0;
      out_miss_q  <= miss_d;
    end
  end

  assign rsp.valid      = out_valid_q;
  assign rsp.hit        = out_hit_q;
  assign rsp.evicted    = out_ev_q;
  assign rsp.evicted_id = out_ev_id_q;
  assign rsp.miss_count = out_miss_q;
endmodule
`default_nettype wire

// ===== verif/lru_directory_checker.sv =====
`timescale 1ns / 1ps
// Checker for lru_cache_lookup: keeps its own LRU directory, predicts one response word
// per accepted request and compares every field. Depends on lcl_pkg, lcl_req_if and
// lcl_rsp_if.
module lru_directory_checker #(
  parameter int WAYS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lcl_pkg::LclCapW-1:0] cfg_wdata_i,
  lcl_req_if                          req,
  lcl_rsp_if                          rsp,
  output int unsigned                 outstanding_o,
  output int unsigned                 mismatches_o
);
  import lcl_pkg::*;

  localparam int RankW = (WAYS > 1) ? $clog2(WAYS) : 1;

  typedef struct packed {
    logic                hit;
    logic                evicted;
    logic [LclIdW-1:0]   evicted_id;
    logic [LclMissW-1:0] miss_count;
  } lookup_word_t;

  logic [LclIdW-1:0]   dir_id   [WAYS];
  logic [RankW-1:0]    dir_rank [WAYS];  // 0 is the newest resident entry
  logic [LclCntW-1:0]  resident;
  logic [LclMissW-1:0] miss_total;
  logic [LclCapW-1:0]  capacity;
  lookup_word_t        expected_words [$];
  int unsigned         mismatches = 0;

  assign mismatches_o = mismatches;

  function automatic logic [LclCntW-1:0] usable_ways();
    logic [LclCntW-1:0] c;
    c = LclCntW'(capacity);
    if (c == 0) c = LclCntW'(1);
    if (c > WAYS) c = LclCntW'(WAYS);
    return c;
  endfunction

  // Age every resident entry newer than limit, then make slot the newest.
  function automatic void promote(int slot, logic [LclCntW-1:0] limit);
    for (int j = 0; j < WAYS; j++)
      if (j < resident && j != slot && LclCntW'(dir_rank[j]) < limit)
        dir_rank[j] = dir_rank[j] + 1'b1;
    dir_rank[slot] = '0;
  endfunction

  function automatic lookup_word_t predict_lookup(logic [LclIdW-1:0] id);
    lookup_word_t       w;
    int                 found;
    int                 victim;
    logic [LclCntW-1:0] lru;
    w      = '0;
    found  = -1;
    victim = 0;
    for (int j = 0; j < WAYS; j++)
      if (found < 0 && j < resident && dir_id[j] == id) found = j;
    if (found >= 0) begin
      w.hit = 1'b1;
      promote(found, LclCntW'(dir_rank[found]));
    end else begin
      if (miss_total != '1) miss_total = miss_total + 1'b1;
      if (resident >= usable_ways()) begin
        // the row never shrinks, so the oldest entry has rank resident-1
        lru = resident - 1'b1;
        for (int j = WAYS - 1; j >= 0; j--)
          if (j < resident && LclCntW'(dir_rank[j]) == lru) victim = j;
        w.evicted    = 1'b1;
        w.evicted_id = dir_id[victim];
        dir_id[victim] = id;
        promote(victim, lru);
      end else begin
        for (int j = 0; j < WAYS; j++)
          if (j < resident) dir_rank[j] = dir_rank[j] + 1'b1;
        dir_id[RankW'(resident)]   = id;
        dir_rank[RankW'(resident)] = '0;
        resident                   = resident + 1'b1;
      end
    end
    w.miss_count = miss_total;
    return w;
  endfunction

  task automatic report_mismatch(string field, logic [LclIdW-1:0] got,
                                 logic [LclIdW-1:0] want);
    $display("[%0t] lookup response %s: got %h, want %h", $time, field, got, want);
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    lookup_word_t want;
    if (!rst_ni) begin
      for (int j = 0; j < WAYS; j++) begin
        dir_id[j]   = '0;
        dir_rank[j] = '0;
      end
      resident      = '0;
      miss_total    = '0;
      capacity      = LclCapW'(16);
      expected_words.delete();
      outstanding_o <= 0;
    end else begin
      // retire the response first: it always belongs to an earlier request
      if (rsp.valid && rsp.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with no request waiting", rsp.evicted_id, '0);
        end else begin
          want = expected_words.pop_front();
          if (rsp.hit !== want.hit)
            report_mismatch("hit", LclIdW'(rsp.hit), LclIdW'(want.hit));
          if (rsp.evicted !== want.evicted)
            report_mismatch("evicted", LclIdW'(rsp.evicted), LclIdW'(want.evicted));
          if (rsp.evicted_id !== want.evicted_id)
            report_mismatch("evicted_id", rsp.evicted_id, want.evicted_id);
          if (rsp.miss_count !== want.miss_count)
            report_mismatch("miss_count", LclIdW'(rsp.miss_count), LclIdW'(want.miss_count));
        end
      end
      if (cfg_we_i) capacity = cfg_wdata_i;
      if (req.valid && req.ready) expected_words.push_back(predict_lookup(req.object_id));
      outstanding_o <= expected_words.size();
    end
  end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Top of the lru_cache_lookup testbench: makes clock, reset, request words, response
// stalls and capacity writes, and gives the verdict. Depends on lcl_pkg, lcl_req_if,
// lcl_rsp_if, lru_cache_lookup and lru_directory_checker.
module tb_top;
  import lcl_pkg::*;

  localparam int          Ways       = 16;
  localparam int          IdlePct    = 24;       // chance of a gap or stall per cycle
  localparam int          PhaseWords = 130;      // random words per capacity setting
  localparam int unsigned CycleLimit = 400_000;  // far beyond the slowest honest run

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [LclCapW-1:0]  cfg_wdata_i;
  logic                steady = 1'b0;  // high: neither side idles
  int unsigned         cycle_count = 0;
  int unsigned         outstanding;
  int unsigned         mismatches;

  lcl_req_if req_ch ();
  lcl_rsp_if rsp_ch ();

  lru_cache_lookup #(
    .WAYS(Ways)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  lru_directory_checker #(
    .WAYS(Ways)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .req          (req_ch),
    .rsp          (rsp_ch),
    .outstanding_o(outstanding),
    .mismatches_o (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // Response side: stall about a quarter of the cycles, never while steady.
  // The decision is redrawn every edge, so stalls land on every phase of a word.
  always @(posedge clk_i) begin
    rsp_ch.ready <= steady || ($urandom_range(99) >= IdlePct);
  end

  function automatic logic [LclIdW-1:0] random_id();
    return {$urandom(), $urandom()};
  endfunction

  // Offer one request word and hold it until accepted. Valid stays high after the
  // handshake so that back-to-back words need no drop in between; a gap lowers it.
  task automatic send_word(input logic [LclIdW-1:0] id);
    while (!steady && $urandom_range(99) < IdlePct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_ch.valid     <= 1'b1;
    req_ch.object_id <= id;
    do @(posedge clk_i); while (!req_ch.ready);
  endtask

  // Drop valid and wait until every response word has come back. The checker updates
  // its count at the edge, so it is read only after an edge, to include the last request.
  task automatic drain_lookups();
    req_ch.valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  // Capacity may only change while the directory is idle.
  task automatic write_capacity(input logic [LclCapW-1:0] value);
    drain_lookups();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    logic [LclIdW-1:0]  pool [$];
    logic [LclIdW-1:0]  id;
    logic [LclIdW-1:0]  last_id;
    int unsigned        pick;
    // Extremes of the register, the clamps (zero and above the way count) and
    // settings that sit below the resident count once the row has filled.
    logic [LclCapW-1:0] phase_caps [10];

    phase_caps = '{LclCapW'(1), LclCapW'(31), LclCapW'(0), LclCapW'(4), LclCapW'(16),
                   LclCapW'(2), LclCapW'(17), LclCapW'(8), LclCapW'(3), LclCapW'(12)};
    last_id = '0;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_wdata_i      <= '0;
    req_ch.valid     <= 1'b0;
    req_ch.object_id <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Small capacity straight from reset: fill two slots, hit, then evict the
    // oldest twice. Covers the all-zero and all-one identifiers.
    write_capacity(LclCapW'(2));
    send_word('0);
    send_word('1);
    send_word('0);
    send_word(64'h8000_0000_0000_0000);
    send_word('1);

    // Full width: grow the row from two to sixteen, overflow it, then hit an older
    // entry, hit the second newest one, and miss once more.
    write_capacity(LclCapW'(16));
    send_word('0);
    for (int k = 1; k <= 14; k++) send_word(LclIdW'(k));
    send_word(LclIdW'(3));
    send_word(LclIdW'(14));
    send_word(64'h5555_5555_5555_5555);

    // Random phases: a fresh pool of identifiers per capacity keeps hits, evictions
    // and repeats of the newest entry all frequent; the rest are wide random ids.
    foreach (phase_caps[p]) begin
      write_capacity(phase_caps[p]);
      steady <= (p == 4);  // one long stretch with no gaps and no stalls
      pool.delete();
      repeat ($urandom_range(24, 2)) pool.push_back(random_id());
      repeat (PhaseWords) begin
        pick = $urandom_range(99);
        if (pick < 10)      id = last_id;
        else if (pick < 75) id = pool[$urandom_range(pool.size() - 1)];
        else                id = random_id();
        send_word(id);
        last_id = id;
      end
    end

    steady <= 1'b0;
    drain_lookups();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
